FILE: rtl/chained_pair_key_hash_table_assert.svh
// Assertion macros shared by the RTL of the chained pair-key hash table.
`ifndef CHAINED_PAIR_KEY_HASH_TABLE_ASSERT_SVH
`define CHAINED_PAIR_KEY_HASH_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPKHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed in chained pair-key hash table.");

// The consequent must hold in the cycle after the antecedent.
`define CPKHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed in chained pair-key hash table.");

`endif

FILE: rtl/cpkht_pkg.sv
// Request codes, status codes and constants of the chained pair-key hash table.
package cpkht_pkg;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_LOOKUP = 3'd2;
    localparam logic [2:0] REQ_UPDATE = 3'd3;
    localparam logic [2:0] REQ_PROBE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_POOL_FULL = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    localparam logic       CFG_BUCKET_COUNT = 1'b0;
    localparam logic       CFG_CONG_LIMIT   = 1'b1;

    localparam int         DEFAULT_BUCKETS = 101;

endpackage

FILE: rtl/chained_pair_key_hash_table.sv
// Top level of the chained pair-key hash table with its bucket and node memories.
// One beat in gives one beat out. The block works on one request at a time and
// takes the next one as soon as the previous result is in the output register.
// A key request first runs the hash, a shift-subtract remainder. A key operation
// then walks the chain through the node memory (up to POOL_NODES nodes), and
// an insert of a new key adds a scan of the used bits (up to POOL_NODES).
// A probe visits up to the effective bucket count of buckets, reading the
// bucket head memory and then, for an occupied bucket, the head node. Bucket
// heads clear at reset through per-bucket valid bits, so no clearing pass is
// needed.
module chained_pair_key_hash_table #(
    parameter int MAX_BUCKETS = 128,
    parameter int POOL_NODES  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_first_key,
    input  logic [7:0]  i_second_key,
    input  logic [15:0] i_count_in,
    input  logic [6:0]  i_start_bucket,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [14:0] o_count_out,
    output logic        o_congested,
    output logic [7:0]  o_found_first,
    output logic [7:0]  o_found_second,
    output logic [6:0]  o_entry_total
);
    import cpkht_pkg::*;

    `include "chained_pair_key_hash_table_assert.svh"

    localparam int BW  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NW  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int PW  = $clog2(POOL_NODES + 1);
    localparam int CW  = $clog2(MAX_BUCKETS + 1);
    localparam int LW  = (CW > 9) ? CW : 9;
    localparam int HW  = 9 + CW;
    localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
    localparam logic [CW-1:0] DEF_NB = (DEFAULT_BUCKETS > MAX_BUCKETS) ?
                                       CW'(MAX_BUCKETS) : CW'(DEFAULT_BUCKETS);

    typedef struct packed {
        logic [7:0]    first;
        logic [7:0]    second;
        logic [14:0]   count;
        logic [PW-1:0] link;
    } t_node;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_HASH  = 12'b000000000010,
        S_HREQ  = 12'b000000000100,
        S_HGET  = 12'b000000001000,
        S_WALK  = 12'b000000010000,
        S_NGET  = 12'b000000100000,
        S_FREE  = 12'b000001000000,
        S_PREQ  = 12'b000010000000,
        S_PGET  = 12'b000100000000,
        S_PNREQ = 12'b001000000000,
        S_PNGET = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } t_state;

    logic [PW-1:0] head_mem [MAX_BUCKETS];
    t_node         node_mem [POOL_NODES];

    t_state                r_state;
    logic [7:0]            r_bucket_count;
    logic [14:0]           r_cong_limit;
    logic [MAX_BUCKETS-1:0] r_hvld;
    logic [POOL_NODES-1:0] r_used;
    logic [PW-1:0]         r_entries;
    logic [2:0]            r_req;
    logic [7:0]            r_k1;
    logic [7:0]            r_k2;
    logic [14:0]           r_cnt;
    logic [8:0]            r_rem;
    logic [3:0]            r_step;
    logic [BW-1:0]         r_bkt;
    logic [BW-1:0]         r_hidx;
    logic [CW-1:0]         r_pcnt;
    logic [PW-1:0]         r_hq;
    logic                  r_hvq;
    t_node                 r_nd_q;
    t_node                 r_prevd;
    logic [PW-1:0]         r_head;
    logic [PW-1:0]         r_cur;
    logic [PW-1:0]         r_prev;
    logic [PW-1:0]         r_steps;
    logic [NW-1:0]         r_scan;
    logic [2:0]            r_rs_status;
    logic [14:0]           r_rs_count;
    logic                  r_rs_cong;
    logic [7:0]            r_rs_f1;
    logic [7:0]            r_rs_f2;
    logic                  r_ovld;
    logic [2:0]            r_o_status;
    logic [14:0]           r_o_count;
    logic                  r_o_cong;
    logic [7:0]            r_o_f1;
    logic [7:0]            r_o_f2;
    logic [6:0]            r_o_entries;

    logic [CW-1:0]  w_nb;
    logic [LW-1:0]  w_nb_ext;
    logic [14:0]    w_limit;
    logic [HW-1:0]  w_dsh;
    logic           w_sub_ok;
    logic [8:0]     w_rem_next;
    logic [PW-1:0]  w_head;
    logic           w_match;
    logic [LW-1:0]  w_hnext;
    logic           w_last_bkt;
    logic           w_free_hit;
    logic           w_hwe;
    logic [BW-1:0]  w_haddr;
    logic [PW-1:0]  w_hdata;
    logic           w_nwe;
    logic [PW-1:0]  w_naddr;
    t_node          w_ndata;

    always_comb begin
        if (r_bucket_count == 8'd0) begin
            w_nb = DEF_NB;
        end else if (LW'(r_bucket_count) > LW'(MAX_BUCKETS)) begin
            w_nb = CW'(MAX_BUCKETS);
        end else begin
            w_nb = CW'(r_bucket_count);
        end
    end

    assign w_nb_ext   = LW'(w_nb);
    assign w_limit    = (r_cong_limit == 15'd0) ? 15'd1 : r_cong_limit;
    assign w_dsh      = HW'(w_nb) << r_step;
    assign w_sub_ok   = HW'(r_rem) >= w_dsh;
    assign w_rem_next = w_sub_ok ? 9'(HW'(r_rem) - w_dsh) : r_rem;
    assign w_head     = r_hvq ? r_hq : NIL;
    assign w_match    = (r_nd_q.first == r_k1) && (r_nd_q.second == r_k2);
    assign w_hnext    = LW'(r_hidx) + LW'(1);
    assign w_last_bkt = (LW'(r_pcnt) + LW'(1)) == w_nb_ext;
    assign w_free_hit = !r_used[r_scan];

    always_comb begin
        w_hwe   = 1'b0;
        w_haddr = r_bkt;
        w_hdata = r_nd_q.link;
        w_nwe   = 1'b0;
        w_naddr = r_cur;
        w_ndata = r_nd_q;
        unique case (r_state)
            S_NGET: begin
                if (w_match && r_req == REQ_REMOVE) begin
                    if (r_prev >= NIL) begin
                        w_hwe = 1'b1;
                    end else begin
                        w_nwe        = 1'b1;
                        w_naddr      = r_prev;
                        w_ndata      = r_prevd;
                        w_ndata.link = r_nd_q.link;
                    end
                end else if (w_match && r_req == REQ_UPDATE) begin
                    w_nwe         = 1'b1;
                    w_ndata.count = r_cnt;
                end
            end
            S_FREE: begin
                if (w_free_hit) begin
                    w_hwe          = 1'b1;
                    w_hdata        = PW'(r_scan);
                    w_nwe          = 1'b1;
                    w_naddr        = PW'(r_scan);
                    w_ndata.first  = r_k1;
                    w_ndata.second = r_k2;
                    w_ndata.count  = r_cnt;
                    w_ndata.link   = r_head;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            head_mem[w_haddr] <= w_hdata;
        end
        if (w_nwe) begin
            node_mem[w_naddr[NW-1:0]] <= w_ndata;
        end
        r_hq   <= head_mem[r_hidx];
        r_hvq  <= r_hvld[r_hidx];
        r_nd_q <= node_mem[r_cur[NW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bucket_count <= 8'(DEFAULT_BUCKETS);
            r_cong_limit   <= 15'd1;
            r_hvld         <= '0;
            r_used         <= '0;
            r_entries      <= '0;
            r_ovld         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BUCKET_COUNT: r_bucket_count <= i_cfg_data[7:0];
                    CFG_CONG_LIMIT:   r_cong_limit   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ovld && i_out_ready && r_state != S_DONE) begin
                r_ovld <= 1'b0;
            end
            if (w_hwe) begin
                r_hvld[w_haddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req       <= i_req_type;
                        r_k1        <= i_first_key;
                        r_k2        <= i_second_key;
                        r_cnt       <= i_count_in[15] ? 15'd0 : i_count_in[14:0];
                        r_rem       <= 9'(i_first_key) + 9'(i_second_key);
                        r_step      <= 4'd8;
                        r_pcnt      <= '0;
                        r_rs_status <= (i_req_type == REQ_PROBE &&
                                        LW'(i_start_bucket) >= w_nb_ext) ? ST_RANGE : ST_OK;
                        r_rs_count  <= '0;
                        r_rs_cong   <= 1'b0;
                        r_rs_f1     <= '0;
                        r_rs_f2     <= '0;
                        case (i_req_type) inside
                            REQ_INSERT, REQ_REMOVE, REQ_LOOKUP, REQ_UPDATE: begin
                                r_state <= S_HASH;
                            end
                            REQ_PROBE: begin
                                if (LW'(i_start_bucket) >= w_nb_ext) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_hidx  <= BW'(i_start_bucket);
                                    r_state <= S_PREQ;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_HASH: begin
                    r_rem <= w_rem_next;
                    if (r_step == 4'd0) begin
                        r_bkt   <= BW'(w_rem_next);
                        r_hidx  <= BW'(w_rem_next);
                        r_state <= S_HREQ;
                    end else begin
                        r_step <= r_step - 4'd1;
                    end
                end
                S_HREQ: r_state <= S_HGET;
                S_HGET: begin
                    r_head  <= w_head;
                    r_cur   <= w_head;
                    r_prev  <= NIL;
                    r_steps <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (r_cur >= NIL || r_steps == PW'(POOL_NODES)) begin
                        if (r_req == REQ_INSERT) begin
                            r_scan  <= '0;
                            r_state <= S_FREE;
                        end else begin
                            r_rs_status <= ST_NOT_FOUND;
                            r_state     <= S_DONE;
                        end
                    end else begin
                        r_state <= S_NGET;
                    end
                end
                S_NGET: begin
                    if (w_match) begin
                        case (r_req)
                            REQ_INSERT: r_rs_status <= ST_DUPLICATE;
                            REQ_REMOVE: begin
                                r_used[r_cur[NW-1:0]] <= 1'b0;
                                if (r_entries != '0) begin
                                    r_entries <= r_entries - PW'(1);
                                end
                            end
                            REQ_LOOKUP: begin
                                r_rs_count <= r_nd_q.count;
                                r_rs_cong  <= r_nd_q.count >= w_limit;
                            end
                            default: begin
                            end
                        endcase
                        r_state <= S_DONE;
                    end else begin
                        r_prev  <= r_cur;
                        r_prevd <= r_nd_q;
                        r_cur   <= r_nd_q.link;
                        r_steps <= r_steps + PW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_FREE: begin
                    if (w_free_hit) begin
                        r_used[r_scan] <= 1'b1;
                        r_entries      <= r_entries + PW'(1);
                        r_state        <= S_DONE;
                    end else if (r_scan == NW'(POOL_NODES - 1)) begin
                        r_rs_status <= ST_POOL_FULL;
                        r_state     <= S_DONE;
                    end else begin
                        r_scan <= r_scan + NW'(1);
                    end
                end
                S_PREQ: r_state <= S_PGET;
                S_PGET, S_PNGET: begin
                    if (r_state == S_PGET && w_head < NIL) begin
                        r_cur   <= w_head;
                        r_state <= S_PNREQ;
                    end else if (r_state == S_PNGET && r_nd_q.first != 8'd0 &&
                                 r_nd_q.second != 8'd0) begin
                        r_rs_f1     <= r_nd_q.first;
                        r_rs_f2     <= r_nd_q.second;
                        r_rs_status <= ST_OK;
                        r_state     <= S_DONE;
                    end else if (w_last_bkt) begin
                        r_rs_status <= ST_NOT_FOUND;
                        r_state     <= S_DONE;
                    end else begin
                        r_pcnt  <= r_pcnt + CW'(1);
                        r_hidx  <= (w_hnext == w_nb_ext) ? '0 : BW'(w_hnext);
                        r_state <= S_PREQ;
                    end
                end
                S_PNREQ: r_state <= S_PNGET;
                S_DONE: begin
                    if (!r_ovld || i_out_ready) begin
                        r_o_status  <= r_rs_status;
                        r_o_count   <= r_rs_count;
                        r_o_cong    <= r_rs_cong;
                        r_o_f1      <= r_rs_f1;
                        r_o_f2      <= r_rs_f2;
                        r_o_entries <= 7'(r_entries);
                        r_ovld      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_ovld;
    assign o_status       = r_o_status;
    assign o_count_out    = r_o_count;
    assign o_congested    = r_o_cong;
    assign o_found_first  = r_o_f1;
    assign o_found_second = r_o_f2;
    assign o_entry_total  = r_o_entries;

    `CPKHT_ASSERT_NEXT(a_busy_after_beat, i_in_valid && o_in_ready, !o_in_ready)
    `CPKHT_ASSERT_NOW(a_entries_bound, 1'b1, r_entries <= PW'(POOL_NODES))
    `CPKHT_ASSERT_NOW(a_bucket_in_range, r_state == S_HREQ, LW'(r_hidx) < w_nb_ext)
    `CPKHT_ASSERT_NOW(a_node_write_in_pool, w_nwe, w_naddr < NIL)

endmodule

FILE: sim/chained_pair_key_hash_table_checker.sv
// Checker that predicts every result beat of the chained pair-key hash table and compares it.
module chained_pair_key_hash_table_checker
    import cpkht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_first_key,
    input  logic [7:0]  i_second_key,
    input  logic [15:0] i_count_in,
    input  logic [6:0]  i_start_bucket,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [2:0]  i_status,
    input  logic [14:0] i_count_out,
    input  logic        i_congested,
    input  logic [7:0]  i_found_first,
    input  logic [7:0]  i_found_second,
    input  logic [6:0]  i_entry_total,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int NB_MAX = 128;
    localparam int NODES = 64;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] count_out;
        logic        congested;
        logic [7:0]  found_first;
        logic [7:0]  found_second;
        logic [6:0]  entry_total;
    } table_reply_t;

    table_reply_t reply_queue[$];
    logic [7:0]  bucket_reg;
    logic [14:0] limit_reg;
    int          head_of[NB_MAX];
    logic [7:0]  key_a[NODES];
    logic [7:0]  key_b[NODES];
    logic [14:0] cnt_of[NODES];
    int          link_of[NODES];
    bit          busy_node[NODES];
    int          held;

    function automatic int table_buckets();
        if (bucket_reg == 0) return DEFAULT_BUCKETS;
        if (bucket_reg > NB_MAX) return NB_MAX;
        return bucket_reg;
    endfunction

    task automatic apply_request(input logic [2:0] req, input logic [7:0] k1,
                                 input logic [7:0] k2, input logic [15:0] raw,
                                 input logic [6:0] start);
        table_reply_t r;
        int nb, b, cur, prev, hit, steps, fr, idx, h;
        logic [14:0] cnt, lim;
        r = '0;
        nb = table_buckets();
        b = (int'(k1) + int'(k2)) % nb;
        cnt = raw[15] ? 15'd0 : raw[14:0];
        lim = (limit_reg == 0) ? 15'd1 : limit_reg;
        hit = NODES;
        prev = NODES;
        cur = head_of[b];
        steps = 0;
        if (req inside {REQ_INSERT, REQ_REMOVE, REQ_LOOKUP, REQ_UPDATE}) begin
            prev = NODES;
            while (cur < NODES && steps < NODES && hit == NODES) begin
                if (key_a[cur] == k1 && key_b[cur] == k2) begin
                    hit = cur;
                end else begin
                    prev = cur;
                    cur = link_of[cur];
                    steps++;
                end
            end
        end
        case (req)
            REQ_INSERT: begin
                if (hit < NODES) begin
                    r.status = ST_DUPLICATE;
                end else begin
                    fr = NODES;
                    for (int i = NODES - 1; i >= 0; i--) if (!busy_node[i]) fr = i;
                    if (fr == NODES) begin
                        r.status = ST_POOL_FULL;
                    end else begin
                        busy_node[fr] = 1;
                        key_a[fr] = k1;
                        key_b[fr] = k2;
                        cnt_of[fr] = cnt;
                        link_of[fr] = head_of[b];
                        head_of[b] = fr;
                        held++;
                    end
                end
            end
            REQ_REMOVE: begin
                if (hit == NODES) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    if (prev < NODES) link_of[prev] = link_of[hit];
                    else head_of[b] = link_of[hit];
                    busy_node[hit] = 0;
                    if (held > 0) held--;
                end
            end
            REQ_LOOKUP: begin
                if (hit == NODES) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.count_out = cnt_of[hit];
                    r.congested = cnt_of[hit] >= lim;
                end
            end
            REQ_UPDATE: begin
                if (hit == NODES) r.status = ST_NOT_FOUND;
                else cnt_of[hit] = cnt;
            end
            REQ_PROBE: begin
                if (start >= nb) begin
                    r.status = ST_RANGE;
                end else begin
                    r.status = ST_NOT_FOUND;
                    idx = start;
                    for (int i = 0; i < nb; i++) begin
                        h = head_of[idx];
                        if (r.status == ST_NOT_FOUND && h < NODES && key_a[h] != 0 &&
                            key_b[h] != 0) begin
                            r.found_first = key_a[h];
                            r.found_second = key_b[h];
                            r.status = ST_OK;
                        end
                        idx = (idx + 1) % nb;
                    end
                end
            end
            default: ;
        endcase
        r.entry_total = held[6:0];
        reply_queue.push_back(r);
    endtask

    always_ff @(posedge i_clk) begin
        table_reply_t want, got;
        if (!i_rst_n) begin
            bucket_reg <= 8'(DEFAULT_BUCKETS);
            limit_reg <= 15'd1;
            o_fail_count <= 0;
            for (int i = 0; i < NB_MAX; i++) head_of[i] = NODES;
            for (int i = 0; i < NODES; i++) busy_node[i] = 0;
            held = 0;
            reply_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BUCKET_COUNT) bucket_reg <= i_cfg_data[7:0];
                else limit_reg <= i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_count_out, i_congested, i_found_first,
                        i_found_second, i_entry_total};
                if (reply_queue.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result beat %p", got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reply_queue.pop_front();
                    if (want !== got) begin
                        if (o_fail_count < 10)
                            $display("result differs: expected %p actual %p", want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                apply_request(i_req_type, i_first_key, i_second_key, i_count_in,
                              i_start_bucket);
        end
    end

    assign o_pending = reply_queue.size();
endmodule

FILE: sim/chained_pair_key_hash_table_test.sv
// Stimulus, clock and verdict for the chained pair-key hash table.
module chained_pair_key_hash_table_test;
    import cpkht_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_idx = 0;
    logic [14:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  req_type = 0;
    logic [7:0]  first_key = 0;
    logic [7:0]  second_key = 0;
    logic [15:0] count_in = 0;
    logic [6:0]  start_bucket = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [2:0]  status;
    logic [14:0] count_out;
    logic        congested;
    logic [7:0]  found_first, found_second;
    logic [6:0]  entry_total;
    int          fail_count, pending;
    int          quiet_cycles = 0;
    bit          steady = 0;
    logic [7:0]  key_pool[16];

    localparam int WATCHDOG = 60000;

    chained_pair_key_hash_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_req_type(req_type), .i_first_key(first_key), .i_second_key(second_key),
        .i_count_in(count_in), .i_start_bucket(start_bucket), .o_out_valid(out_valid),
        .i_out_ready(out_ready), .o_status(status), .o_count_out(count_out),
        .o_congested(congested), .o_found_first(found_first),
        .o_found_second(found_second), .o_entry_total(entry_total)
    );

    chained_pair_key_hash_table_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_req_type(req_type), .i_first_key(first_key), .i_second_key(second_key),
        .i_count_in(count_in), .i_start_bucket(start_bucket), .i_out_valid(out_valid),
        .i_out_ready(out_ready), .i_status(status), .i_count_out(count_out),
        .i_congested(congested), .i_found_first(found_first),
        .i_found_second(found_second), .i_entry_total(entry_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 25);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("chained_pair_key_hash_table: mismatch");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] req, input logic [7:0] k1,
                                input logic [7:0] k2, input logic [15:0] cnt,
                                input logic [6:0] start);
        while (!steady && $urandom_range(99) < 25) begin
            in_valid <= 0;
            @(negedge i_clk);
        end
        in_valid <= 1;
        req_type <= req;
        first_key <= k1;
        second_key <= k2;
        count_in <= cnt;
        start_bucket <= start;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic idx, input logic [14:0] value);
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        cfg_we <= 1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(input int items);
        logic [2:0] req;
        int pick;
        for (int n = 0; n < items; n++) begin
            pick = $urandom_range(15);
            if ($urandom_range(99) < 85) begin
                req = 3'($urandom_range(4));
                send_request(req, key_pool[pick], key_pool[$urandom_range(15)],
                             16'($urandom), 7'($urandom));
            end else begin
                send_request(3'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                             7'($urandom));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) key_pool[i] = 8'($urandom);
        key_pool[0] = 8'd0;
        key_pool[1] = 8'hff;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_request(REQ_PROBE, 0, 0, 0, 0);
        send_request(REQ_LOOKUP, 1, 2, 0, 0);
        send_request(REQ_INSERT, 8'hff, 8'hff, 16'h7fff, 0);
        send_request(REQ_INSERT, 8'hff, 8'hff, 16'h0005, 0);
        send_request(REQ_INSERT, 0, 8'h05, 16'h8000, 0);
        send_request(REQ_INSERT, 8'h05, 0, 16'hffff, 0);
        send_request(REQ_INSERT, 8'h04, 8'h01, 16'd3, 0);
        send_request(REQ_LOOKUP, 8'hff, 8'hff, 0, 0);
        send_request(REQ_LOOKUP, 0, 8'h05, 0, 0);
        send_request(REQ_UPDATE, 8'h04, 8'h01, 16'd0, 0);
        send_request(REQ_UPDATE, 8'h09, 8'h09, 16'd0, 0);
        send_request(REQ_PROBE, 0, 0, 0, 7'd5);
        send_request(REQ_PROBE, 0, 0, 0, 7'd100);
        send_request(REQ_PROBE, 0, 0, 0, 7'd101);
        send_request(REQ_PROBE, 0, 0, 0, 7'd127);
        send_request(REQ_REMOVE, 0, 8'h05, 0, 0);
        send_request(REQ_REMOVE, 0, 8'h05, 0, 0);
        send_request(3'd5, 8'h11, 8'h22, 16'h1234, 7'h33);
        send_request(3'd7, 8'hff, 8'hff, 16'hffff, 7'h7f);
        for (int i = 0; i < 66; i++) send_request(REQ_INSERT, 8'(i), 8'(i * 3 + 1), 16'(i), 0);
        random_phase(150);
        write_register(CFG_CONG_LIMIT, 15'h7fff);
        write_register(CFG_BUCKET_COUNT, 15'd1);
        random_phase(150);
        steady = 1;
        random_phase(100);
        steady = 0;
        write_register(CFG_BUCKET_COUNT, 15'd128);
        write_register(CFG_CONG_LIMIT, 15'd0);
        random_phase(150);
        write_register(CFG_BUCKET_COUNT, 15'd0);
        write_register(CFG_CONG_LIMIT, 15'd200);
        random_phase(100);
        write_register(CFG_BUCKET_COUNT, 15'hff);
        write_register(CFG_CONG_LIMIT, 15'h5555);
        random_phase(100);
        write_register(CFG_BUCKET_COUNT, 15'h7f07);
        random_phase(50);
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("chained_pair_key_hash_table: match");
        end else begin
            $display("chained_pair_key_hash_table: mismatch");
        end
        $finish;
    end
endmodule
